>>> hdl/ogbr_pkg.sv
`default_nettype none

package ogbr_pkg;

	// default array size, in character cells
	localparam int DEF_CELL_COLUMNS = 40;
	localparam int DEF_CELL_ROWS    = 25;

	// ten lines per draw, six store accesses per line
	localparam logic [3:0] LAST_LINE  = 4'd9;
	localparam logic [2:0] LAST_PHASE = 3'd5;
	localparam logic [2:0] FIRST_WRITE_PHASE = 3'd3;

	typedef enum logic {
		ACT_DRAW = 1'b0,
		ACT_READ = 1'b1
	} action_t;

	typedef struct packed {
		logic        action;
		logic [5:0]  cell_col;
		logic [4:0]  cell_row;
		logic [2:0]  line_sel;
		logic [7:0]  ink;
		logic [63:0] glyph;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic [7:0] colour_byte;
		logic       error;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_DRAW,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_DISPATCH,
		OP_DRAW,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] line;
		logic [2:0] phase;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_read;
		logic room_ok;
		logic out_free;
	} stat_t;

	// double each of four bits into a 2-bit pixel
	function automatic logic [7:0] px2(input logic [3:0] n);
		return {n[3], n[3], n[2], n[2], n[1], n[1], n[0], n[0]};
	endfunction

	// font row idx, row 0 in the top byte
	function automatic logic [7:0] glyph_row(input logic [63:0] g, input logic [2:0] idx);
		return 8'(g >> (6'd56 - {idx, 3'b000}));
	endfunction

	// outline mask (upper byte) and glyph line (lower byte) for draw line k
	function automatic logic [15:0] line_bits(input logic [63:0] g, input logic [3:0] k);
		logic [7:0] pv;
		logic [7:0] cu;
		logic [7:0] nx;
		logic [7:0] f6;
		logic [7:0] m;
		logic [7:0] l;
		pv = '0;
		cu = '0;
		nx = '0;
		l  = '0;
		f6 = glyph_row(g, 3'd6);
		priority if (k == 4'd0) begin
			m = glyph_row(g, 3'd0);
		end else if (k <= 4'd7) begin
			if (k != 4'd1) begin
				pv = glyph_row(g, 3'(k - 4'd2));
			end
			cu = glyph_row(g, 3'(k - 4'd1));
			nx = glyph_row(g, 3'(k));
			m  = pv | cu | nx | ((pv | cu) >> 1);
			l  = cu;
		end else if (k == 4'd8) begin
			m = f6 | (f6 >> 1);
		end else begin
			m = f6 >> 1;
		end
		return {m, l};
	endfunction

endpackage

`default_nettype wire

>>> hdl/ogbr_stream_if.sv
`default_nettype none

interface ogbr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/ogbr_ctrl.sv
`default_nettype none

module ogbr_ctrl
	import ogbr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t     state_q;
	state_t     state_d;
	logic [3:0] line_q;
	logic [2:0] phase_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (!stat.is_read && stat.room_ok) state_d = ST_DRAW;
				else state_d = ST_FINISH;
			end
			ST_DRAW: begin
				if (line_q == LAST_LINE && phase_q == LAST_PHASE) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		in_ready  = 1'b0;
		cmd.op    = OP_NONE;
		cmd.line  = line_q;
		cmd.phase = phase_q;
		unique case (state_q)
			ST_CLEAR:    cmd.op = OP_CLEAR;
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_DISPATCH: cmd.op = OP_DISPATCH;
			ST_DRAW:     cmd.op = OP_DRAW;
			ST_FINISH: begin
				if (stat.out_free) cmd.op = OP_FINISH;
			end
			default:     cmd.op = OP_NONE;
		endcase
	end

	// state and line/phase counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			line_q  <= '0;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DRAW) begin
				if (phase_q == LAST_PHASE) begin
					phase_q <= '0;
					line_q  <= (line_q == LAST_LINE) ? 4'd0 : line_q + 4'd1;
				end else begin
					phase_q <= phase_q + 3'd1;
				end
			end else begin
				line_q  <= '0;
				phase_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/ogbr_datapath.sv
`default_nettype none

module ogbr_datapath
	import ogbr_pkg::*;
#(
	parameter int CELL_COLUMNS = DEF_CELL_COLUMNS,
	parameter int CELL_ROWS    = DEF_CELL_ROWS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t in_item,
	input  wire cmd_t     cmd,
	output stat_t         stat,
	output logic          out_valid,
	output out_item_t     out_item,
	input  wire logic     out_ready
);

	localparam int LINE_STRIDE  = CELL_COLUMNS * 8;
	localparam int BITMAP_BYTES = CELL_COLUMNS * CELL_ROWS * 8;
	localparam int COLOUR_BYTES = CELL_COLUMNS * CELL_ROWS;
	localparam int BA_W         = $clog2(BITMAP_BYTES);
	localparam int CA_W         = $clog2(COLOUR_BYTES);

	logic [7:0] bm_mem [BITMAP_BYTES];
	logic [7:0] cl_mem [COLOUR_BYTES];

	in_item_t    item_q;
	logic [BA_W-1:0] clr_q;
	logic [7:0]  bm_rd_q;
	logic [7:0]  cl_rd_q;
	logic [7:0]  b0_q;
	logic [7:0]  b1_q;
	logic [7:0]  b2_q;
	logic        out_valid_q;
	out_item_t   out_item_q;

	logic            in_range;
	logic [BA_W-1:0] base_c;
	logic [BA_W-1:0] line_off;
	logic [BA_W-1:0] phase_off;
	logic [CA_W-1:0] cidx_c;
	logic [15:0]     lb;
	logic [7:0]      m;
	logic [7:0]      l1;
	logic [7:0]      d;
	logic [7:0]      e;
	logic [7:0]      b0_new;
	logic [7:0]      b1_new;
	logic [7:0]      b2_new;

	logic            bm_we;
	logic            bm_re;
	logic [BA_W-1:0] bm_addr;
	logic [7:0]      bm_wdata;
	logic            cl_we;
	logic            cl_re;
	logic [CA_W-1:0] cl_addr;

	// position checks on the held item
	assign in_range = ({1'b0, item_q.cell_col} < 7'(CELL_COLUMNS))
		&& ({2'b00, item_q.cell_row} < 7'(CELL_ROWS));
	assign stat.room_ok = (item_q.cell_col <= 6'(CELL_COLUMNS - 3))
		&& ({1'b0, item_q.cell_row} <= 6'(CELL_ROWS - 2));
	assign stat.is_read  = (item_q.action == ACT_READ);
	assign stat.clr_last = (clr_q == BA_W'(BITMAP_BYTES - 1));
	assign stat.out_free = !out_valid_q || out_ready;

	// cell addresses
	assign base_c = BA_W'(item_q.cell_row) * BA_W'(LINE_STRIDE)
		+ BA_W'({item_q.cell_col, 3'b000});
	assign cidx_c = CA_W'(item_q.cell_row) * CA_W'(CELL_COLUMNS) + CA_W'(item_q.cell_col);
	assign line_off = (cmd.line < 4'd8) ? BA_W'(cmd.line[2:0])
		: BA_W'(LINE_STRIDE) + BA_W'(cmd.line[0]);

	always_comb begin
		unique case (cmd.phase)
			3'd0, 3'd3: phase_off = BA_W'(0);
			3'd1, 3'd4: phase_off = BA_W'(8);
			default:    phase_off = BA_W'(16);
		endcase
	end

	// outline and glyph line merge
	assign lb = line_bits(item_q.glyph, cmd.line);
	assign m  = lb[15:8];
	assign l1 = lb[7:0] >> 1;
	assign d  = m | (m >> 1) | (m >> 2);
	assign e  = (m << 3) | (m << 2) | (m << 1);
	assign b0_new = (b0_q & ~px2(d[7:4])) | px2(l1[7:4]);
	assign b1_new = (b1_q & ~px2(d[3:0])) | px2(l1[3:0]);
	assign b2_new = b2_q & ~px2(e[3:0]);

	// store port control
	always_comb begin
		bm_we    = 1'b0;
		bm_re    = 1'b0;
		bm_addr  = base_c + line_off + phase_off;
		bm_wdata = '0;
		cl_we    = 1'b0;
		cl_re    = 1'b0;
		cl_addr  = cidx_c;
		unique case (cmd.op)
			OP_CLEAR: begin
				bm_we   = 1'b1;
				bm_addr = clr_q;
				cl_we   = (clr_q < BA_W'(COLOUR_BYTES));
				cl_addr = clr_q[CA_W-1:0];
			end
			OP_DISPATCH: begin
				bm_re   = stat.is_read && in_range;
				cl_re   = stat.is_read && in_range;
				bm_addr = base_c + BA_W'(item_q.line_sel);
			end
			OP_DRAW: begin
				bm_re = (cmd.phase < FIRST_WRITE_PHASE);
				bm_we = (cmd.phase >= FIRST_WRITE_PHASE);
				unique case (cmd.phase)
					3'd3:    bm_wdata = b0_new;
					3'd4:    bm_wdata = b1_new;
					default: bm_wdata = b2_new;
				endcase
				cl_we   = (cmd.line == 4'd0) && (cmd.phase < 3'd2);
				cl_addr = cidx_c + CA_W'(cmd.phase[0]);
			end
			default: begin
			end
		endcase
	end

	// bitmap store, single port
	always_ff @(posedge clk) begin
		if (bm_we) bm_mem[bm_addr] <= bm_wdata;
		if (bm_re) bm_rd_q <= bm_mem[bm_addr];
	end

	// colour store, single port
	always_ff @(posedge clk) begin
		if (cl_we) cl_mem[cl_addr] <= (cmd.op == OP_CLEAR) ? 8'h00 : item_q.ink;
		if (cl_re) cl_rd_q <= cl_mem[cl_addr];
	end

	// item hold and read-back bytes
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) item_q <= in_item;
		if (cmd.op == OP_DRAW) begin
			if (cmd.phase == 3'd1) b0_q <= bm_rd_q;
			if (cmd.phase == 3'd2) b1_q <= bm_rd_q;
			if (cmd.phase == 3'd3) b2_q <= bm_rd_q;
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == OP_CLEAR && !stat.clr_last) begin
			clr_q <= clr_q + BA_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FINISH) begin
			out_item_q.pixel_byte  <= (stat.is_read && in_range) ? bm_rd_q : 8'h00;
			out_item_q.colour_byte <= (stat.is_read && in_range) ? cl_rd_q : 8'h00;
			out_item_q.error       <= !stat.is_read && !stat.room_ok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

>>> hdl/outlined_glyph_bitmap_render.sv
// Outlined glyph renderer over a cell-organised bitmap and colour store.
// in_ch (valid/ready, payload in_item_t) takes a draw or a read item;
// out_ch (valid/ready, payload out_item_t) returns exactly one result item
// per input item, in order.
// After a draw is accepted it passes through a dispatch step, ten pixel
// lines of three reads and three writes each through the single bitmap
// store port, and a finish step.
// The two colour writes share the first line's cycles on the colour store
// port. A read, or a draw ignored for lack of room, goes from its dispatch
// step straight to the finish step.
// One item is in work at a time; the input opens again once the previous
// one's result is loaded into the output register.
// After reset a clearing pass over the CELL_COLUMNS*CELL_ROWS*8 bitmap
// addresses (8000 at the default size) zeroes both stores; in_ch.ready
// stays low during it.
// When the receiver stalls, the result waits in the output register; a
// further item can still be taken and worked, and its result waits until
// the output register frees up.
`default_nettype none

module outlined_glyph_bitmap_render
	import ogbr_pkg::*;
#(
	parameter int CELL_COLUMNS = DEF_CELL_COLUMNS,
	parameter int CELL_ROWS    = DEF_CELL_ROWS
) (
	input wire logic      clk,
	input wire logic      arst_n,
	ogbr_stream_if.sink   in_ch,
	ogbr_stream_if.source out_ch
);

	cmd_t      cmd;
	stat_t     stat;
	logic      in_ready;
	logic      out_valid;
	out_item_t out_item;

	// sequencer
	ogbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stores and pixel logic
	ogbr_datapath #(
		.CELL_COLUMNS (CELL_COLUMNS),
		.CELL_ROWS    (CELL_ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_ch.payload),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_item  (out_item),
		.out_ready (out_ch.ready)
	);

	assign in_ch.ready    = in_ready;
	assign out_ch.valid   = out_valid;
	assign out_ch.payload = out_item;

`ifndef ASSERT_OFF
	// no item is taken while the stores are being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CLEAR) |-> !in_ch.ready)
		else $error("item accepted during clearing pass");

	// an accepted item keeps the input side closed in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input still open after accepting an item");

	// a result shows up only after the sequencer finished an item
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(cmd.op == OP_FINISH))
		else $error("result appeared without a finished item");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_outlined_glyph_bitmap_render.sv
module tb_outlined_glyph_bitmap_render;
	timeunit 1ns;
	timeprecision 1ps;

	import ogbr_pkg::*;

	localparam int COLS         = DEF_CELL_COLUMNS;
	localparam int ROWS         = DEF_CELL_ROWS;
	localparam int LINE_STRIDE  = COLS * 8;
	localparam int BITMAP_BYTES = COLS * ROWS * 8;
	localparam int COLOUR_BYTES = COLS * ROWS;

	localparam int unsigned LIMIT_CYCLES   = 1_000_000;
	localparam int unsigned RAND_PER_PHASE = 463;
	localparam int unsigned DRAIN_CYCLES   = 80;

	// idle and stall percentages of the four phases
	localparam int unsigned SRC_IDLE [4]  = '{0, 75, 0, 37};
	localparam int unsigned SNK_STALL [4] = '{0, 0, 75, 37};

	typedef struct packed {
		in_item_t  it;
		logic      fixed;
		out_item_t want;
	} plan_row_t;

	// directed items; fixed rows carry their result, the others go to the shadow model
	localparam plan_row_t PLAN [25] = '{
		'{'{ACT_READ, 6'd0,  5'd0,  3'd0, 8'h00, 64'h0}, 1'b1, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd39, 5'd24, 3'd7, 8'hff, 64'h0}, 1'b1, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_DRAW, 6'd38, 5'd0,  3'd0, 8'h11, 64'hffff_ffff_ffff_ffff},
			1'b1, '{8'h00, 8'h00, 1'b1}},
		'{'{ACT_DRAW, 6'd0,  5'd24, 3'd0, 8'h22, 64'hffff_ffff_ffff_ffff},
			1'b1, '{8'h00, 8'h00, 1'b1}},
		'{'{ACT_DRAW, 6'd63, 5'd31, 3'd7, 8'hff, 64'hffff_ffff_ffff_ffff},
			1'b1, '{8'h00, 8'h00, 1'b1}},
		'{'{ACT_READ, 6'd40, 5'd0,  3'd0, 8'h00, 64'h0}, 1'b1, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd63, 5'd31, 3'd7, 8'h00, 64'h0}, 1'b1, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd0,  5'd25, 3'd0, 8'h00, 64'h0}, 1'b1, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_DRAW, 6'd0,  5'd0,  3'd0, 8'hff, 64'hffff_ffff_ffff_ffff},
			1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd0,  5'd0,  3'd0, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd1,  5'd0,  3'd7, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd2,  5'd0,  3'd3, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd0,  5'd1,  3'd0, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd0,  5'd1,  3'd1, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_DRAW, 6'd37, 5'd23, 3'd5, 8'h5a, 64'haa55_aa55_aa55_aa55},
			1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd37, 5'd23, 3'd4, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd38, 5'd23, 3'd4, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd39, 5'd23, 3'd4, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd37, 5'd24, 3'd1, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd38, 5'd24, 3'd0, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_DRAW, 6'd1,  5'd0,  3'd0, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd1,  5'd0,  3'd5, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd0,  5'd0,  3'd5, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_DRAW, 6'd20, 5'd12, 3'd2, 8'h81, 64'h183c_7eff_ff7e_3c18},
			1'b0, '{8'h00, 8'h00, 1'b0}},
		'{'{ACT_READ, 6'd21, 5'd12, 3'd3, 8'h00, 64'h0}, 1'b0, '{8'h00, 8'h00, 1'b0}}
	};

	logic clk;
	logic arst_n;

	ogbr_stream_if #(.payload_t(in_item_t))  in_ch ();
	ogbr_stream_if #(.payload_t(out_item_t)) out_ch ();

	outlined_glyph_bitmap_render #(
		.CELL_COLUMNS(COLS),
		.CELL_ROWS(ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// shadow copy of both stores
	logic [7:0] shadow_bitmap [BITMAP_BYTES];
	logic [7:0] shadow_colour [COLOUR_BYTES];

	out_item_t   pending_bytes [$];
	int unsigned bad_cnt;
	int unsigned cycle_cnt;
	int unsigned src_idle_pct;
	int unsigned snk_stall_pct;

	// each of four bits becomes a 2-bit pixel
	function automatic logic [7:0] widen_nibble(input logic [3:0] n);
		logic [7:0] w;
		for (int b = 0; b < 4; b++) begin
			w[2*b]     = n[b];
			w[2*b + 1] = n[b];
		end
		return w;
	endfunction

	// clear the dilated outline on three bytes, then OR in the shifted glyph line
	function automatic void paint_line(input int unsigned addr, input logic [7:0] m,
			input logic [7:0] gl);
		logic [7:0] d;
		logic [7:0] e;
		logic [7:0] sh;
		if (addr + 16 >= BITMAP_BYTES) begin
			return;
		end
		d  = m | (m >> 1) | (m >> 2);
		e  = (m << 3) | (m << 2) | (m << 1);
		sh = gl >> 1;
		shadow_bitmap[addr]      = (shadow_bitmap[addr] & ~widen_nibble(d[7:4]))
			| widen_nibble(sh[7:4]);
		shadow_bitmap[addr + 8]  = (shadow_bitmap[addr + 8] & ~widen_nibble(d[3:0]))
			| widen_nibble(sh[3:0]);
		shadow_bitmap[addr + 16] = shadow_bitmap[addr + 16] & ~widen_nibble(e[3:0]);
	endfunction

	// expected result of one item; draws update the shadow stores
	function automatic out_item_t shadow_render(input in_item_t it);
		out_item_t   res;
		logic [7:0]  fr [8];
		logic [7:0]  prev;
		logic [7:0]  pc;
		int unsigned base;
		int unsigned cidx;
		res  = '0;
		if (it.action == ACT_READ) begin
			if (it.cell_col < COLS && it.cell_row < ROWS) begin
				res.pixel_byte  = shadow_bitmap[it.cell_row * LINE_STRIDE + it.cell_col * 8
					+ it.line_sel];
				res.colour_byte = shadow_colour[it.cell_row * COLS + it.cell_col];
			end
			return res;
		end
		if (it.cell_col > COLS - 3 || it.cell_row > ROWS - 2) begin
			res.error = 1'b1;
			return res;
		end
		base = it.cell_row * LINE_STRIDE + it.cell_col * 8;
		cidx = it.cell_row * COLS + it.cell_col;
		for (int r = 0; r < 8; r++) begin
			fr[r] = it.glyph[63 - 8*r -: 8];
		end
		shadow_colour[cidx]     = it.ink;
		shadow_colour[cidx + 1] = it.ink;
		paint_line(base, fr[0], 8'h00);
		prev = 8'h00;
		for (int i = 0; i < 7; i++) begin
			pc = prev | fr[i];
			paint_line(base + i + 1, pc | fr[i + 1] | (pc >> 1), fr[i]);
			prev = fr[i];
		end
		paint_line(base + LINE_STRIDE, fr[6] | (fr[6] >> 1), 8'h00);
		paint_line(base + LINE_STRIDE + 1, fr[6] >> 1, 8'h00);
		return res;
	endfunction

	// offer one item after a random gap, hold it until taken
	task automatic drive_item(input in_item_t it, input logic fixed, input out_item_t want);
		out_item_t pred;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= it;
		do begin
			@(posedge clk);
		end while (in_ch.ready !== 1'b1);
		pred = shadow_render(it);
		pending_bytes.push_back(fixed ? want : pred);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: check each taken item, then stall at random
	initial begin
		out_item_t want;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (pending_bytes.size() == 0) begin
					if (bad_cnt < 10) begin
						$display("unexpected item: pixel %02h colour %02h error %0b",
							out_ch.payload.pixel_byte, out_ch.payload.colour_byte,
							out_ch.payload.error);
					end
					bad_cnt++;
				end else begin
					want = pending_bytes.pop_front();
					if (out_ch.payload.pixel_byte !== want.pixel_byte
							|| out_ch.payload.colour_byte !== want.colour_byte
							|| out_ch.payload.error !== want.error) begin
						if (bad_cnt < 10) begin
							$display("mismatch (want/got): pixel %02h/%02h colour %02h/%02h error %0b/%0b",
								want.pixel_byte, out_ch.payload.pixel_byte,
								want.colour_byte, out_ch.payload.colour_byte,
								want.error, out_ch.payload.error);
						end
						bad_cnt++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// reset, directed items, then random items in four idling phases
	initial begin
		in_item_t    it;
		int unsigned roll;
		logic [5:0]  near_col;
		logic [4:0]  near_row;
		cycle_cnt     = 0;
		bad_cnt       = 0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		near_col      = '0;
		near_row      = '0;
		for (int a = 0; a < BITMAP_BYTES; a++) begin
			shadow_bitmap[a] = 8'h00;
		end
		for (int a = 0; a < COLOUR_BYTES; a++) begin
			shadow_colour[a] = 8'h00;
		end
		arst_n        <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.payload <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int k = 0; k < 25; k++) begin
			drive_item(PLAN[k].it, PLAN[k].fixed, PLAN[k].want);
		end

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct  = SRC_IDLE[ph];
			snk_stall_pct = SNK_STALL[ph];
			for (int unsigned n = 0; n < RAND_PER_PHASE; n++) begin
				it.action   = ACT_DRAW;
				it.line_sel = 3'($urandom_range(0, 7));
				it.ink      = 8'($urandom_range(0, 255));
				case ($urandom_range(0, 9))
					0: it.glyph = '1;
					1: it.glyph = '0;
					2, 3: it.glyph = {$urandom, $urandom} & {$urandom, $urandom};
					default: it.glyph = {$urandom, $urandom};
				endcase
				roll = $urandom_range(0, 99);
				if (roll < 45) begin
					// draw with room, leaning toward the edges
					case ($urandom_range(0, 9))
						0: it.cell_col = 6'(COLS - 3);
						1: it.cell_col = 6'd0;
						default: it.cell_col = 6'($urandom_range(0, COLS - 3));
					endcase
					case ($urandom_range(0, 9))
						0: it.cell_row = 5'(ROWS - 2);
						1: it.cell_row = 5'd0;
						default: it.cell_row = 5'($urandom_range(0, ROWS - 2));
					endcase
					near_col = it.cell_col;
					near_row = it.cell_row;
				end else if (roll < 85) begin
					// read within the footprint of the latest draw
					it.action   = ACT_READ;
					it.cell_col = 6'(near_col + $urandom_range(0, 2));
					it.cell_row = 5'(near_row + $urandom_range(0, 1));
				end else if (roll < 95) begin
					it.action   = ACT_READ;
					it.cell_col = 6'($urandom_range(0, COLS - 1));
					it.cell_row = 5'($urandom_range(0, ROWS - 1));
				end else if (roll < 98) begin
					// read outside the array
					it.action   = ACT_READ;
					it.cell_col = 6'($urandom_range(0, 63));
					it.cell_row = 5'($urandom_range(0, 31));
					if ($urandom_range(0, 1) == 0) begin
						it.cell_col = 6'($urandom_range(COLS, 63));
					end else begin
						it.cell_row = 5'($urandom_range(ROWS, 31));
					end
				end else begin
					// draw with no room for the wide glyph
					it.cell_col = 6'($urandom_range(0, 63));
					it.cell_row = 5'($urandom_range(0, 31));
					if ($urandom_range(0, 1) == 0) begin
						it.cell_col = 6'($urandom_range(COLS - 2, 63));
					end else begin
						it.cell_row = 5'($urandom_range(ROWS - 1, 31));
					end
				end
				drive_item(it, 1'b0, '0);
			end
		end
		in_ch.valid <= 1'b0;

		// drain, then watch for stray items
		while (pending_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bad_cnt == 0 && pending_bytes.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
